// File: hdl/bqss_pkg.sv
// shared types, constants and codes for the soft-switching biquad
package bqss_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF   = 32;
  localparam int RATIO_W          = 17;
  localparam int STEP_W           = 16;
  localparam int CUT_W            = 16;
  localparam int IDX_W            = 3;
  localparam int CNT_W            = 3;
  localparam int RND_SHIFT        = 15;

  localparam logic signed [RATIO_W-1:0] RATIO_ONE = 17'sd32768;
  localparam logic signed [RATIO_W-1:0] RATIO_NEG = -17'sd32768;
  localparam logic [STEP_W-1:0]         STEP_RESET = 16'd328;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [IDX_W-1:0] REG_B0   = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1   = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2   = 3'd2;
  localparam logic [IDX_W-1:0] REG_A1   = 3'd3;
  localparam logic [IDX_W-1:0] REG_A2   = 3'd4;
  localparam logic [IDX_W-1:0] REG_STEP = 3'd5;

  localparam logic [CNT_W-1:0] TAP_X   = 3'd0;
  localparam logic [CNT_W-1:0] TAP_X1  = 3'd1;
  localparam logic [CNT_W-1:0] TAP_X2  = 3'd2;
  localparam logic [CNT_W-1:0] TAP_Y1  = 3'd3;
  localparam logic [CNT_W-1:0] TAP_Y2  = 3'd4;
  localparam logic [CNT_W-1:0] TAP_END = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_BMUL,
    ST_BADD
  } state_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
    logic acc_sub;
  } alu_ctl_t;

endpackage

// File: hdl/bqss_cfg.sv
// configuration register file: coefficients and fade step
module bqss_cfg #(
  parameter int COEF_WIDTH = bqss_pkg::COEF_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bqss_pkg::IDX_W-1:0]          cfg_index,
  input  logic [COEF_WIDTH-1:0]               cfg_wdata,
  output logic signed [COEF_WIDTH-1:0]        coef_b0,
  output logic signed [COEF_WIDTH-1:0]        coef_b1,
  output logic signed [COEF_WIDTH-1:0]        coef_b2,
  output logic signed [COEF_WIDTH-1:0]        coef_a1,
  output logic signed [COEF_WIDTH-1:0]        coef_a2,
  output logic [bqss_pkg::STEP_W-1:0]         ratio_step
);

  localparam logic signed [COEF_WIDTH-1:0] B0_RESET =
    {{(COEF_WIDTH-1){1'b0}}, 1'b1} << (COEF_WIDTH - 4);

  logic signed [COEF_WIDTH-1:0]  b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [bqss_pkg::STEP_W-1:0]   step_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r   <= B0_RESET;
      b1_r   <= '0;
      b2_r   <= '0;
      a1_r   <= '0;
      a2_r   <= '0;
      step_r <= bqss_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bqss_pkg::REG_B0:   b0_r   <= cfg_wdata;
        bqss_pkg::REG_B1:   b1_r   <= cfg_wdata;
        bqss_pkg::REG_B2:   b2_r   <= cfg_wdata;
        bqss_pkg::REG_A1:   a1_r   <= cfg_wdata;
        bqss_pkg::REG_A2:   a2_r   <= cfg_wdata;
        bqss_pkg::REG_STEP: step_r <= cfg_wdata[bqss_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign coef_b0    = b0_r;
  assign coef_b1    = b1_r;
  assign coef_b2    = b2_r;
  assign coef_a1    = a1_r;
  assign coef_a2    = a2_r;
  assign ratio_step = step_r;

endmodule

// File: hdl/bqss_alu.sv
// shared multiplier with product register and accumulator
module bqss_alu #(
  parameter int AW = bqss_pkg::SAMPLE_WIDTH_DEF + 1,
  parameter int BW = bqss_pkg::COEF_WIDTH_DEF
) (
  input  logic                       clk,
  input  bqss_pkg::alu_ctl_t         ctl,
  input  logic signed [AW-1:0]       op_a,
  input  logic signed [BW-1:0]       op_b,
  output logic signed [AW+BW-1:0]    prod,
  output logic signed [AW+BW+2:0]    acc
);

  localparam int PW    = AW + BW;
  localparam int ACC_W = PW + 3;

  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      if (ctl.acc_sub) begin
        acc_r <= acc_r - ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

// File: hdl/biquad_filter_soft_switch_top.sv
// soft-switching direct-form-I biquad: sequencer, state and blend around one multiplier
//
//   channel   direction  handshake               payload
//   in_       input      in_valid / in_stall     in_cmd, in_sample, in_cutoff
//   out_      output     out_valid / out_stall   out_filtered
//   cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// a sample request runs through accept, multiply-accumulate over the five taps,
// round and saturate, blend multiply, blend add
// the single multiplier is shared by all five taps and the blend product
// a restart request is taken in idle, leaves the sequencer idle and produces no output
// reset is synchronous; it clears the delays, fade ratio and cutoff and arms priming
// a stalled output holds the finished sample; the next request is taken meanwhile
module biquad_filter_soft_switch_top #(
  parameter int SAMPLE_WIDTH = bqss_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bqss_pkg::COEF_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic [bqss_pkg::CUT_W-1:0]          in_cutoff,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_filtered,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bqss_pkg::IDX_W-1:0]          cfg_index,
  input  logic [COEF_WIDTH-1:0]               cfg_wdata
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int RW    = bqss_pkg::RATIO_W;
  localparam int AW    = SW + 1;
  localparam int BW    = (COEF_WIDTH > RW) ? COEF_WIDTH : RW;
  localparam int PW    = AW + BW;
  localparam int ACC_W = PW + 3;
  localparam int FRAC  = COEF_WIDTH - 4;
  localparam int FW    = RW + 2;

  localparam logic signed [ACC_W-1:0] ACC_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [PW-1:0]    PROD_HALF =
    {{(PW-1){1'b0}}, 1'b1} << (bqss_pkg::RND_SHIFT - 1);
  localparam logic signed [FW-1:0]    F_ONE = FW'(bqss_pkg::RATIO_ONE);
  localparam logic signed [FW-1:0]    F_NEG = FW'(bqss_pkg::RATIO_NEG);

  logic signed [COEF_WIDTH-1:0]     coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [bqss_pkg::STEP_W-1:0]      ratio_step;

  bqss_pkg::state_t                 state_r, state_nxt;
  logic [bqss_pkg::CNT_W-1:0]       cnt_r;
  logic signed [SW-1:0]             x_r, d1_r, d2_r, yd1_r, yd2_r, y_r;
  logic                             prime_r;
  logic signed [RW-1:0]             ratio_r;
  logic [bqss_pkg::CUT_W-1:0]       cut_r;
  logic                             out_valid_r;
  logic signed [SW-1:0]             out_data_r;

  bqss_pkg::alu_ctl_t               ctl;
  logic signed [AW-1:0]             op_a;
  logic signed [BW-1:0]             op_b;
  logic signed [PW-1:0]             prod;
  logic signed [ACC_W-1:0]          acc;

  logic                             in_acc;
  logic                             out_free;
  logic                             finish;
  logic signed [ACC_W-1:0]          acc_rnd;
  logic signed [ACC_W-1:0]          acc_sh;
  logic signed [SW-1:0]             y_nxt;
  logic signed [PW-1:0]             prod_sh;
  logic signed [SW-1:0]             blend;
  logic signed [SW-1:0]             result;
  logic signed [FW-1:0]             ratio_wide;
  logic signed [FW-1:0]             ratio_up, ratio_dn;
  logic signed [RW-1:0]             ratio_nxt;
  logic                             fade_dn, fade_up;

  bqss_cfg #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .coef_b0    (coef_b0),
    .coef_b1    (coef_b1),
    .coef_b2    (coef_b2),
    .coef_a1    (coef_a1),
    .coef_a2    (coef_a2),
    .ratio_step (ratio_step)
  );

  bqss_alu #(
    .AW(AW),
    .BW(BW)
  ) u_alu (
    .clk  (clk),
    .ctl  (ctl),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bqss_pkg::ST_IDLE: begin
        if (in_acc && in_cmd == bqss_pkg::CMD_SAMPLE) begin
          state_nxt = bqss_pkg::ST_MAC;
        end
      end
      bqss_pkg::ST_MAC: begin
        if (cnt_r == bqss_pkg::TAP_END) begin
          state_nxt = bqss_pkg::ST_ROUND;
        end
      end
      bqss_pkg::ST_ROUND: state_nxt = bqss_pkg::ST_BMUL;
      bqss_pkg::ST_BMUL:  state_nxt = bqss_pkg::ST_BADD;
      bqss_pkg::ST_BADD: begin
        if (out_free) begin
          state_nxt = bqss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bqss_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall    = 1'b1;
    finish      = 1'b0;
    ctl.clr     = 1'b0;
    ctl.mul_en  = 1'b0;
    ctl.acc_en  = 1'b0;
    ctl.acc_sub = 1'b0;
    unique case (state_r)
      bqss_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ctl.clr  = 1'b1;
      end
      bqss_pkg::ST_MAC: begin
        ctl.mul_en  = (cnt_r != bqss_pkg::TAP_END);
        ctl.acc_en  = (cnt_r != bqss_pkg::TAP_X);
        ctl.acc_sub = (cnt_r == bqss_pkg::TAP_Y2) || (cnt_r == bqss_pkg::TAP_END);
      end
      bqss_pkg::ST_ROUND: ;
      bqss_pkg::ST_BMUL:  ctl.mul_en = 1'b1;
      bqss_pkg::ST_BADD:  finish = out_free;
      default: ;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    op_a = AW'(x_r);
    op_b = BW'(coef_b0);
    if (state_r == bqss_pkg::ST_BMUL) begin
      op_a = AW'(x_r) - AW'(y_r);
      op_b = BW'(ratio_r);
    end else begin
      unique case (cnt_r)
        bqss_pkg::TAP_X1: begin
          op_a = AW'(d1_r);
          op_b = BW'(coef_b1);
        end
        bqss_pkg::TAP_X2: begin
          op_a = AW'(d2_r);
          op_b = BW'(coef_b2);
        end
        bqss_pkg::TAP_Y1: begin
          op_a = AW'(yd1_r);
          op_b = BW'(coef_a1);
        end
        bqss_pkg::TAP_Y2: begin
          op_a = AW'(yd2_r);
          op_b = BW'(coef_a2);
        end
        default: ;
      endcase
    end
  end

  // round half up and saturate the biquad sum
  always_comb begin
    acc_rnd = acc + ACC_HALF;
    acc_sh  = acc_rnd >>> FRAC;
    if (acc_sh > SMAX) begin
      y_nxt = SMAX[SW-1:0];
    end else if (acc_sh < SMIN) begin
      y_nxt = SMIN[SW-1:0];
    end else begin
      y_nxt = acc_sh[SW-1:0];
    end
  end

  // blend and fade step
  always_comb begin
    fade_dn    = (cut_r != '0) && (ratio_r > 0);
    fade_up    = (cut_r == '0) && (ratio_r < 0);
    prod_sh    = (prod + PROD_HALF) >>> bqss_pkg::RND_SHIFT;
    blend      = (fade_dn ? y_r : x_r) + prod_sh[SW-1:0];
    ratio_wide = FW'(ratio_r);
    ratio_dn   = ratio_wide - $signed({2'b00, ratio_step});
    ratio_up   = ratio_wide + $signed({2'b00, ratio_step});
    ratio_nxt  = ratio_r;
    if (fade_dn) begin
      ratio_nxt = (ratio_dn < F_NEG) ? bqss_pkg::RATIO_NEG : ratio_dn[RW-1:0];
    end else if (fade_up) begin
      ratio_nxt = (ratio_up > F_ONE) ? bqss_pkg::RATIO_ONE : ratio_up[RW-1:0];
    end
    if (fade_dn || fade_up) begin
      result = blend;
    end else if (cut_r == '0) begin
      result = x_r;
    end else begin
      result = y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bqss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (state_r == bqss_pkg::ST_MAC) begin
      cnt_r <= cnt_r + 1'b1;
    end else begin
      cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r    <= '0;
      d2_r    <= '0;
      yd1_r   <= '0;
      yd2_r   <= '0;
      prime_r <= 1'b1;
      ratio_r <= '0;
      cut_r   <= '0;
    end else begin
      if (in_acc) begin
        if (in_cmd == bqss_pkg::CMD_RESTART) begin
          if (cut_r != '0 && in_cutoff == '0) begin
            ratio_r <= bqss_pkg::RATIO_NEG;
          end else if (cut_r != in_cutoff) begin
            ratio_r <= bqss_pkg::RATIO_ONE;
          end
          cut_r   <= in_cutoff;
          d1_r    <= '0;
          d2_r    <= '0;
          yd1_r   <= '0;
          yd2_r   <= '0;
          prime_r <= 1'b1;
        end else begin
          if (prime_r) begin
            d1_r  <= in_sample;
            d2_r  <= in_sample;
            yd1_r <= in_sample;
            yd2_r <= in_sample;
          end
          prime_r <= 1'b0;
        end
      end
      if (state_r == bqss_pkg::ST_ROUND) begin
        d2_r  <= d1_r;
        d1_r  <= x_r;
        yd2_r <= yd1_r;
        yd1_r <= y_nxt;
      end
      if (finish) begin
        ratio_r <= ratio_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_sample;
    end
    if (state_r == bqss_pkg::ST_ROUND) begin
      y_r <= y_nxt;
    end
    if (finish) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bqss_pkg::ST_BADD))
    else $error("output raised outside the blend step");

  a_restart_primes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == bqss_pkg::CMD_RESTART |=> prime_r)
    else $error("restart did not arm priming");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ratio_r <= bqss_pkg::RATIO_ONE) && (ratio_r >= bqss_pkg::RATIO_NEG))
    else $error("fade ratio out of range");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == bqss_pkg::ST_IDLE)
    else $error("request accepted while busy");

  a_mac_to_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bqss_pkg::ST_MAC && cnt_r == bqss_pkg::TAP_END
      |=> state_r == bqss_pkg::ST_ROUND)
    else $error("accumulate sequence did not end in rounding");

endmodule

// File: verif/tb_biquad_filter_soft_switch_top.sv
// testbench for the soft-switching biquad: directed table, random phases, in-bench prediction
module tb_biquad_filter_soft_switch_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bqss_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bqss_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {CS_MILD, CS_WILD, CS_EDGE} coef_style_t;

  typedef struct {
    bit                           is_cfg;
    logic                         cmd;
    logic [31:0]                  sample;
    logic [bqss_pkg::CUT_W-1:0]   cutoff;
    logic [bqss_pkg::IDX_W-1:0]   idx;
    logic [31:0]                  wdata;
    bit                           typed;
    logic [31:0]                  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_cmd;
  logic signed [31:0] in_sample;
  logic [bqss_pkg::CUT_W-1:0] in_cutoff;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_filtered;
  logic cfg_valid;
  logic cfg_ready;
  logic [bqss_pkg::IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  logic signed [31:0] cf_b0, cf_b1, cf_b2, cf_a1, cf_a2;
  logic [bqss_pkg::STEP_W-1:0] fade_step;
  logic signed [31:0] x_d1, x_d2, y_d1, y_d2;
  bit prime_armed;
  int fade;
  logic [bqss_pkg::CUT_W-1:0] cut_code;

  logic signed [31:0] pending_filtered[$];
  dir_row_t dir_tab[$];
  logic [bqss_pkg::IDX_W-1:0] coef_regs[5] = '{bqss_pkg::REG_B0, bqss_pkg::REG_B1,
                                               bqss_pkg::REG_B2, bqss_pkg::REG_A1,
                                               bqss_pkg::REG_A2};
  int bad_count = 0;
  int burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_tick = 0;

  biquad_filter_soft_switch_top #(
    .SAMPLE_WIDTH(32),
    .COEF_WIDTH  (32)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_sample   (in_sample),
    .in_cutoff   (in_cutoff),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_filtered(out_filtered),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int clamp_fade(int r);
    if (r > int'(bqss_pkg::RATIO_ONE)) return int'(bqss_pkg::RATIO_ONE);
    if (r < int'(bqss_pkg::RATIO_NEG)) return int'(bqss_pkg::RATIO_NEG);
    return r;
  endfunction

  task automatic apply_reg(input logic [bqss_pkg::IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      bqss_pkg::REG_B0:   cf_b0 = data;
      bqss_pkg::REG_B1:   cf_b1 = data;
      bqss_pkg::REG_B2:   cf_b2 = data;
      bqss_pkg::REG_A1:   cf_a1 = data;
      bqss_pkg::REG_A2:   cf_a2 = data;
      bqss_pkg::REG_STEP: fade_step = data[bqss_pkg::STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_filtered(input logic cmd, input logic signed [31:0] smp,
                                  input logic [bqss_pkg::CUT_W-1:0] code, output bit has_out,
                                  output logic signed [31:0] res);
    logic signed [71:0] acc;
    logic signed [31:0] y;
    longint diff;
    has_out = 1'b0;
    res = '0;
    if (cmd == bqss_pkg::CMD_RESTART) begin
      if (cut_code != 0 && code == 0) begin
        fade = int'(bqss_pkg::RATIO_NEG);
      end else if (cut_code != code) begin
        fade = int'(bqss_pkg::RATIO_ONE);
      end
      cut_code = code;
      x_d1 = '0;
      x_d2 = '0;
      y_d1 = '0;
      y_d2 = '0;
      prime_armed = 1'b1;
    end else begin
      if (prime_armed) begin
        prime_armed = 1'b0;
        x_d1 = smp;
        x_d2 = smp;
        y_d1 = smp;
        y_d2 = smp;
      end
      acc = 72'(cf_b0) * 72'(smp) + 72'(cf_b1) * 72'(x_d1) + 72'(cf_b2) * 72'(x_d2)
          - 72'(cf_a1) * 72'(y_d1) - 72'(cf_a2) * 72'(y_d2);
      acc = (acc + 72'sd134217728) >>> 28;
      if (acc > 72'sd2147483647) begin
        y = 32'sh7FFFFFFF;
      end else if (acc < -72'sd2147483648) begin
        y = 32'sh80000000;
      end else begin
        y = acc[31:0];
      end
      x_d2 = x_d1;
      x_d1 = smp;
      y_d2 = y_d1;
      y_d1 = y;
      diff = longint'(smp) - longint'(y);
      res = y;
      if (cut_code != 0) begin
        if (fade > 0) begin
          res = 32'(longint'(y) + ((diff * longint'(fade) + 64'sd16384) >>> 15));
          fade = clamp_fade(fade - int'(fade_step));
        end
      end else if (fade < 0) begin
        res = 32'(longint'(smp) + ((diff * longint'(fade) + 64'sd16384) >>> 15));
        fade = clamp_fade(fade + int'(fade_step));
      end else begin
        res = smp;
      end
      has_out = 1'b1;
    end
  endtask

  function automatic dir_row_t req_row(logic cmd, logic [31:0] smp,
                                       logic [bqss_pkg::CUT_W-1:0] code,
                                       bit typed, logic [31:0] want);
    dir_row_t r;
    r = '{default: '0};
    r.cmd = cmd;
    r.sample = smp;
    r.cutoff = code;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [bqss_pkg::IDX_W-1:0] idx, logic [31:0] data);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.wdata = data;
    return r;
  endfunction

  function automatic logic [31:0] rand_sample();
    logic [31:0] edges[4] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
    case ($urandom_range(0, 9))
      0:       return edges[$urandom_range(0, 3)];
      1, 2, 3: return 32'($urandom_range(0, 4000)) - 32'd2000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(coef_style_t style);
    logic [31:0] edges[4] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h10000000};
    case (style)
      CS_MILD: return 32'($urandom_range(0, 32'h10000000)) - 32'h08000000;
      CS_EDGE: return edges[$urandom_range(0, 3)];
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [bqss_pkg::IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_req(input logic cmd, input logic [31:0] smp,
                          input logic [bqss_pkg::CUT_W-1:0] code,
                          input bit typed, input logic [31:0] want);
    bit has_out;
    logic signed [31:0] res;
    int gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_sample <= smp;
    in_cutoff <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_filtered(cmd, smp, code, has_out, res);
    if (has_out) pending_filtered.push_back(typed ? want : res);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_tick == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_tick <= $urandom_range(50, 300);
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 6);
      STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
      default:        out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin : out_check
    logic signed [31:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_filtered.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("unexpected output: got %0d", out_filtered);
      end else begin
        want = pending_filtered.pop_front();
        if (out_filtered !== want) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("filtered mismatch: expected %0d got %0d", want, out_filtered);
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL biquad_filter_soft_switch_top");
    $finish;
  end

  initial begin
    int n_items;
    coef_style_t style;
    logic [bqss_pkg::CUT_W-1:0] code;
    logic [bqss_pkg::STEP_W-1:0] step;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= bqss_pkg::CMD_SAMPLE;
    in_sample <= '0;
    in_cutoff <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= bqss_pkg::REG_B0;
    cfg_wdata <= '0;

    cf_b0 = 32'sh10000000;
    cf_b1 = '0;
    cf_b2 = '0;
    cf_a1 = '0;
    cf_a2 = '0;
    fade_step = bqss_pkg::STEP_RESET;
    x_d1 = '0;
    x_d2 = '0;
    y_d1 = '0;
    y_d2 = '0;
    prime_armed = 1'b1;
    fade = 0;
    cut_code = '0;

    // raw passes after reset; unity b0 keeps the output equal to the input
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h7FFFFFFF, '0, 1, 32'h7FFFFFFF));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h80000000, '1, 1, 32'h80000000));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h00000000, '0, 1, 32'h00000000));
    dir_tab.push_back(req_row(bqss_pkg::CMD_RESTART, 32'hFFFFFFFF, 16'hFFFF, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'd12345, '0, 1, 32'd12345));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'hFFFFFFFF, '0, 1, 32'hFFFFFFFF));
    dir_tab.push_back(req_row(bqss_pkg::CMD_RESTART, 32'h0, 16'hFFFF, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h7FFFFFFF, '0, 1, 32'h7FFFFFFF));
    // extreme gains, saturation and the largest step
    dir_tab.push_back(cfg_row(bqss_pkg::REG_B0, 32'h7FFFFFFF));
    dir_tab.push_back(cfg_row(bqss_pkg::REG_B1, 32'h80000000));
    dir_tab.push_back(cfg_row(bqss_pkg::REG_B2, 32'h7FFFFFFF));
    dir_tab.push_back(cfg_row(bqss_pkg::REG_A1, 32'h80000000));
    dir_tab.push_back(cfg_row(bqss_pkg::REG_A2, 32'h7FFFFFFF));
    dir_tab.push_back(cfg_row(bqss_pkg::REG_STEP, 32'h0000FFFF));
    dir_tab.push_back(req_row(bqss_pkg::CMD_RESTART, 32'h0, 16'd1, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h7FFFFFFF, '0, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h80000000, '0, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h00000001, '0, 0, '0));
    // switching off fades back toward raw, then a zero step, spare register writes and a switch back on
    dir_tab.push_back(req_row(bqss_pkg::CMD_RESTART, 32'h0, 16'd0, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h55555555, '0, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'hAAAAAAAA, '0, 0, '0));
    dir_tab.push_back(cfg_row(bqss_pkg::REG_STEP, 32'hFFFF0000));
    dir_tab.push_back(cfg_row(REG_SPARE_LO, 32'hFFFFFFFF));
    dir_tab.push_back(cfg_row(REG_SPARE_HI, 32'h12345678));
    dir_tab.push_back(req_row(bqss_pkg::CMD_RESTART, 32'h0, 16'd0, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h40000000, '0, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_RESTART, 32'h0, 16'h8000, 0, '0));
    dir_tab.push_back(req_row(bqss_pkg::CMD_SAMPLE, 32'h7FFFFFFF, '0, 0, '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        quiesce();
        write_reg(dir_tab[i].idx, dir_tab[i].wdata);
      end else begin
        send_req(dir_tab[i].cmd, dir_tab[i].sample, dir_tab[i].cutoff,
                 dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      quiesce();
      style = coef_style_t'(ph % 3);
      foreach (coef_regs[r]) begin
        if (ph == 0 || $urandom_range(0, 2) != 0) write_reg(coef_regs[r], rand_coef(style));
      end
      if (ph == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: step = 16'($urandom_range(1, 400));
          1: step = 16'($urandom_range(1, 2000));
          2: step = 16'($urandom_range(1, 32768));
          3: step = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h8000;
          default: step = 16'($urandom_range(100, 600));
        endcase
        write_reg(bqss_pkg::REG_STEP, {16'($urandom), step});
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      end
      n_items = $urandom_range(80, 110);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          case ($urandom_range(0, 9))
            0, 1, 2: code = '0;
            3, 4:    code = cut_code;
            5, 6:    code = 16'($urandom_range(1, 4));
            default: code = 16'($urandom_range(0, 65535));
          endcase
          send_req(bqss_pkg::CMD_RESTART, rand_sample(), code, 0, '0);
        end else begin
          send_req(bqss_pkg::CMD_SAMPLE, rand_sample(), 16'($urandom), 0, '0);
        end
      end
    end

    quiesce();
    if (bad_count == 0 && pending_filtered.size() == 0) begin
      $display("PASS biquad_filter_soft_switch_top");
    end else begin
      $display("FAIL biquad_filter_soft_switch_top");
    end
    $finish;
  end

endmodule
